/* hdl/idq_pkg.sv */
package idq_pkg;

	// Ring capacity and the widths that follow from it.
	localparam int DEPTH  = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 7;
	localparam int CMP_W  = CNT_W + POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_READ       = 3'd4,
		CMD_WRITE      = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// One access to the slot memory; a command never reads and writes at once.
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wr_data;
	} mem_req_t;

	// Slot index of the element at an offset from the front. Both operands are
	// below DEPTH, so one compare and subtract brings the sum back into range.
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
		input logic [ADDR_W-1:0] offset);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= (ADDR_W + 1)'(DEPTH)) begin
			sum = sum - (ADDR_W + 1)'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

/* hdl/idq_store.sv */
module idq_store import idq_pkg::*; (
	input  logic              clk,
	input  mem_req_t          req,
	output logic [DATA_W-1:0] rd_data
);

	// Slot storage: one port, read data registered.
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.addr];
		end
	end

endmodule

/* hdl/indexed_deque.sv */
// Double-ended queue of signed 32-bit values in a ring of DEPTH slots. Each
// input transaction carries one command (push back, push front, pop back, pop
// front, read at a position or write at a position, counted from the front)
// and yields exactly one output transaction with the popped or read value
// (zero otherwise), a status code (ok, empty on pop, full on push, position
// out of range) and the element count after the command. A failed command
// leaves the contents alone; codes 6 and 7 do nothing and report ok. A
// command passes the registered read of the single-port slot memory and
// then the output register; no new command is taken while one is in
// flight. Commands are handled one at a time, so a read never overlaps
// a write to the same slot.
module indexed_deque import idq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] data_in,
	input  logic [POS_W-1:0]         position,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] data_out,
	output logic [STAT_W-1:0]        status,
	output logic [OCC_W-1:0]         occupancy
);

	// Architectural state: front slot index and number of elements held.
	logic [ADDR_W-1:0] front_q, front_d;
	logic [CNT_W-1:0]  count_q, count_d;

	// Command in flight while the memory read completes.
	logic              pend_s1;
	logic              rd_s1, rd_d;
	status_t           status_s1, status_d;
	logic [CNT_W-1:0]  count_s1;

	// Output register holding the finished result.
	logic              out_valid_q;
	logic [DATA_W-1:0] data_out_q;
	status_t           status_q;
	logic [CNT_W-1:0]  occ_q;

	logic              fire;
	logic              full, empty, pos_ok;
	mem_req_t          req;
	logic [DATA_W-1:0] rd_data;

	// A new command enters only when no command is in flight and the output
	// register is free or being emptied in this cycle.
	assign in_ready = !pend_s1 && (!out_valid_q || out_ready);
	assign fire     = in_valid && in_ready;

	always_comb begin
		full     = count_q == CNT_W'(DEPTH);
		empty    = count_q == '0;
		pos_ok   = CMP_W'(position) < CMP_W'(count_q);
		req      = '0;
		req.wr_data = data_in;
		front_d  = front_q;
		count_d  = count_q;
		status_d = ST_OK;
		rd_d     = 1'b0;
		unique case (cmd_t'(command))
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					req.wr_en = 1'b1;
					req.addr  = wrap_add(front_q, ADDR_W'(count_q));
					count_d   = count_q + CNT_W'(1);
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					front_d   = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - ADDR_W'(1);
					req.wr_en = 1'b1;
					req.addr  = front_d;
					count_d   = count_q + CNT_W'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					req.rd_en = 1'b1;
					req.addr  = wrap_add(front_q, ADDR_W'(count_q - CNT_W'(1)));
					rd_d      = 1'b1;
					count_d   = count_q - CNT_W'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					req.rd_en = 1'b1;
					req.addr  = front_q;
					rd_d      = 1'b1;
					front_d   = (front_q == ADDR_W'(DEPTH - 1)) ? '0 : front_q + ADDR_W'(1);
					count_d   = count_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (!pos_ok) begin
					status_d = ST_RANGE;
				end else begin
					req.rd_en = 1'b1;
					req.addr  = wrap_add(front_q, ADDR_W'(CMP_W'(position)));
					rd_d      = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (!pos_ok) begin
					status_d = ST_RANGE;
				end else begin
					req.wr_en = 1'b1;
					req.addr  = wrap_add(front_q, ADDR_W'(CMP_W'(position)));
				end
			end
			default: begin
			end
		endcase
		// Nothing touches the memory unless the command is actually taken.
		if (!fire) begin
			req.wr_en = 1'b0;
			req.rd_en = 1'b0;
		end
	end

	idq_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= fire;
			if (fire) begin
				front_q <= front_d;
				count_q <= count_d;
			end
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the in-flight fields, then the result itself once
	// the memory data has arrived.
	always_ff @(posedge clk) begin
		if (fire) begin
			rd_s1     <= rd_d;
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
		if (pend_s1) begin
			data_out_q <= rd_s1 ? rd_data : '0;
			status_q   <= status_s1;
			occ_q      <= count_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;
	assign occupancy = OCC_W'(occ_q);

	// The element count never goes beyond the ring capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above capacity");

	// A command in flight always lands in the output register next cycle.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> out_valid_q)
		else $error("in-flight command lost its result");

	// A successful push grows the count by exactly one.
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !full && (command == CMD_PUSH_BACK || command == CMD_PUSH_FRONT))
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not grow the count");

	// A full report only comes from a ring that is really full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && status_s1 == ST_FULL) |-> count_q == CNT_W'(DEPTH))
		else $error("full reported on a ring with room");

	// The memory is never read and written in the same cycle.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr_en && req.rd_en))
		else $error("read and write in one cycle");

endmodule
